// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the B-spline weight block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the active-low reset is asserted.
`define BWG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("bwg_checker: property violated");

// Concurrent assertion that is also checked during reset.
`define BWG_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bwg_checker: property violated");

`endif

// ----- hdl/bwg_pkg.sv -----
// Shared types and constants of the B-spline weight and gradient block.
// No dependencies.
package bwg_pkg;

    localparam int NUM_LANE_STAGES  = 6;
    localparam int NUM_MERGE_STAGES = 3;
    localparam int NUM_STAGES       = 1 + NUM_LANE_STAGES + NUM_MERGE_STAGES;

    localparam logic [31:0] INV_SPACING_RESET = 32'h0001_0000;
    // Largest weight the rounding chain can produce is (2/3)^3 in Q0.16.
    localparam logic [15:0] WEIGHT_BOUND      = 16'd19420;

    // Per-axis kernel value and derivative magnitude, both Q0.30.
    typedef struct packed {
        logic        neg;
        logic [29:0] m;
        logic [29:0] n;
    } axis_t;

    // Load enables of the pipeline stages, driven by the top level.
    typedef struct packed {
        logic [NUM_MERGE_STAGES-1:0] merge;
        logic [NUM_LANE_STAGES-1:0]  lane;
    } pipe_en_t;

endpackage

// ----- hdl/bwg_lane.sv -----
// One axis lane: scaled distance, branch selection and cubic B-spline value/derivative.
// Depends on bwg_pkg.
module bwg_lane (
    input  logic              aclk,
    input  bwg_pkg::pipe_en_t pipe_en,
    input  logic [31:0]       pos_particle,
    input  logic [31:0]       pos_node,
    input  logic [31:0]       inv_spacing,
    output bwg_pkg::axis_t    axis_out
);

    localparam logic [1:0] BR_INNER = 2'd0;
    localparam logic [1:0] BR_OUTER = 2'd1;
    localparam logic [1:0] BR_ZERO  = 2'd2;

    localparam logic [51:0] HALF_DIV = 52'd786432;          // 3 * 2^18
    localparam logic [51:0] FOUR_Q48 = 52'd4 << 48;
    localparam logic [63:0] DIV3_RECIP = 64'h0000_0000_AAAA_AAAB;

    // Stage 1: distance magnitude and sign.
    logic [32:0] diff;
    logic [32:0] mag_next;
    logic [32:0] mag_reg;
    logic        neg1_reg;

    assign diff     = {pos_particle[31], pos_particle} - {pos_node[31], pos_node};
    assign mag_next = diff[32] ? (~diff + 33'd1) : diff;

    always_ff @(posedge aclk) begin
        if (pipe_en.lane[0]) begin
            mag_reg  <= mag_next;
            neg1_reg <= !diff[32] && (diff != 33'd0);
        end
    end

    // Stage 2: scale by the inverse spacing and pick the branch from the Q32.32 product.
    logic [64:0] prod_a;
    logic [1:0]  br_next;
    logic [16:0] t_reg;
    logic [1:0]  br2_reg;
    logic        neg2_reg;

    assign prod_a = 65'(mag_reg) * 65'(inv_spacing);

    always_comb begin
        if (prod_a[64:32] == 33'd0) begin
            br_next = BR_INNER;
        end else if (prod_a[64:33] == 32'd0) begin
            br_next = BR_OUTER;
        end else begin
            br_next = BR_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.lane[1]) begin
            t_reg    <= prod_a[32:16];
            br2_reg  <= br_next;
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: the base is t on the inner branch and 2 - t on the outer one.
    logic [17:0] r_full;
    logic [16:0] s_next;
    logic [33:0] sq_next;
    logic [16:0] s3_reg;
    logic [32:0] sq3_reg;
    logic [1:0]  br3_reg;
    logic        neg3_reg;

    assign r_full  = 18'h2_0000 - {1'b0, t_reg};
    assign s_next  = (br2_reg == BR_INNER) ? {1'b0, t_reg[15:0]} : r_full[16:0];
    assign sq_next = 34'(s_next) * 34'(s_next);

    always_ff @(posedge aclk) begin
        if (pipe_en.lane[2]) begin
            s3_reg   <= s_next;
            sq3_reg  <= sq_next[32:0];
            br3_reg  <= br2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: cube and the derivative magnitude (|N'| rounded to Q0.30).
    logic [49:0] cube_next;
    logic [34:0] two_m;
    logic [34:0] m_sum;
    logic [29:0] m_next;
    logic [49:0] cube4_reg;
    logic [32:0] sq4_reg;
    logic [29:0] m4_reg;
    logic [1:0]  br4_reg;
    logic        neg4_reg;

    assign cube_next = 50'(sq3_reg) * 50'(s3_reg);

    always_comb begin
        case (br3_reg)
            BR_INNER: two_m = (35'(s3_reg[15:0]) << 18) - 35'(sq3_reg) * 35'd3;
            BR_OUTER: two_m = 35'(sq3_reg);
            default:  two_m = 35'd0;
        endcase
        m_sum  = two_m + 35'd4;
        m_next = m_sum[32:3];
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.lane[3]) begin
            cube4_reg <= cube_next;
            sq4_reg   <= sq3_reg;
            m4_reg    <= m_next;
            br4_reg   <= br3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    // Stage 5: 6N in Q.48 plus the rounding half, then drop the power-of-two part
    // of the divisor 3 * 2^19.
    logic [51:0] six_n;
    logic [31:0] y_next;
    logic [31:0] y5_reg;
    logic [29:0] m5_reg;
    logic        neg5_reg;

    always_comb begin
        case (br4_reg)
            BR_INNER: six_n = 52'(cube4_reg) * 52'd3 + FOUR_Q48
                              - (52'(sq4_reg) << 16) * 52'd6 + HALF_DIV;
            BR_OUTER: six_n = 52'(cube4_reg) + HALF_DIV;
            default:  six_n = 52'd0;
        endcase
        y_next = six_n[50:19];
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.lane[4]) begin
            y5_reg   <= y_next;
            m5_reg   <= m4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Stage 6: exact divide by three through the reciprocal, valid for any 32-bit value.
    logic [63:0] q_prod;
    logic [29:0] n6_reg;
    logic [29:0] m6_reg;
    logic        neg6_reg;

    assign q_prod = 64'(y5_reg) * DIV3_RECIP;

    always_ff @(posedge aclk) begin
        if (pipe_en.lane[5]) begin
            n6_reg   <= q_prod[62:33];
            m6_reg   <= m5_reg;
            neg6_reg <= neg5_reg;
        end
    end

    assign axis_out.n   = n6_reg;
    assign axis_out.m   = m6_reg;
    assign axis_out.neg = neg6_reg;

endmodule

// ----- hdl/bwg_merge.sv -----
// Merging stages: weight product and gradient products of the three axis lanes.
// Depends on bwg_pkg.
module bwg_merge (
    input  logic              aclk,
    input  bwg_pkg::pipe_en_t pipe_en,
    input  bwg_pkg::axis_t    axis_x,
    input  bwg_pkg::axis_t    axis_y,
    input  bwg_pkg::axis_t    axis_z,
    input  logic [31:0]       inv_spacing,
    output logic [15:0]       weight,
    output logic [31:0]       grad_x,
    output logic [31:0]       grad_y,
    output logic [31:0]       grad_z
);

    // Round half up and drop 30 fraction bits.
    function automatic logic [33:0] rnd30(input logic [63:0] p);
        logic [63:0] s;
        s = p + (64'd1 << 29);
        return s[63:30];
    endfunction

    // Apply the sign and saturate to the signed 32-bit range.
    function automatic logic [31:0] sat_signed(input logic [33:0] g, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (g > 34'h0_8000_0000) ? 32'h8000_0000 : (~g[31:0] + 32'd1);
        end else begin
            r = (g > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : g[31:0];
        end
        return r;
    endfunction

    // Stage 1: first products.
    logic [33:0] w1_full, gx1_full, gy1_full, gz1_full;
    logic [30:0] w1_reg, gx1_reg, gy1_reg, gz1_reg;
    logic [29:0] ny1_reg, nz1_reg;
    logic [2:0]  neg1_reg;

    assign w1_full  = rnd30(64'(axis_x.n) * 64'(axis_y.n));
    assign gx1_full = rnd30(64'(axis_x.m) * 64'(axis_y.n));
    assign gy1_full = rnd30(64'(axis_y.m) * 64'(axis_x.n));
    assign gz1_full = rnd30(64'(axis_z.m) * 64'(axis_x.n));

    always_ff @(posedge aclk) begin
        if (pipe_en.merge[0]) begin
            w1_reg   <= w1_full[30:0];
            gx1_reg  <= gx1_full[30:0];
            gy1_reg  <= gy1_full[30:0];
            gz1_reg  <= gz1_full[30:0];
            ny1_reg  <= axis_y.n;
            nz1_reg  <= axis_z.n;
            neg1_reg <= {axis_z.neg, axis_y.neg, axis_x.neg};
        end
    end

    // Stage 2: second products; the weight is finished here.
    logic [63:0] w2_sum;
    logic [19:0] w2_full;
    logic [15:0] w2_next;
    logic [33:0] gx2_full, gy2_full, gz2_full;
    logic [15:0] w2_reg, w3_reg;
    logic [30:0] gx2_reg, gy2_reg, gz2_reg;
    logic [2:0]  neg2_reg;

    assign w2_sum   = 64'(w1_reg) * 64'(nz1_reg) + (64'd1 << 43);
    assign w2_full  = w2_sum[63:44];
    assign w2_next  = (w2_full > 20'h0_FFFF) ? 16'hFFFF : w2_full[15:0];
    assign gx2_full = rnd30(64'(gx1_reg) * 64'(nz1_reg));
    assign gy2_full = rnd30(64'(gy1_reg) * 64'(nz1_reg));
    assign gz2_full = rnd30(64'(gz1_reg) * 64'(ny1_reg));

    always_ff @(posedge aclk) begin
        if (pipe_en.merge[1]) begin
            w2_reg   <= w2_next;
            gx2_reg  <= gx2_full[30:0];
            gy2_reg  <= gy2_full[30:0];
            gz2_reg  <= gz2_full[30:0];
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: scale by the inverse spacing, sign and saturate.
    logic [33:0] gx3_full, gy3_full, gz3_full;
    logic [31:0] gx3_reg, gy3_reg, gz3_reg;

    assign gx3_full = rnd30(64'(gx2_reg) * 64'(inv_spacing));
    assign gy3_full = rnd30(64'(gy2_reg) * 64'(inv_spacing));
    assign gz3_full = rnd30(64'(gz2_reg) * 64'(inv_spacing));

    always_ff @(posedge aclk) begin
        if (pipe_en.merge[2]) begin
            w3_reg  <= w2_reg;
            gx3_reg <= sat_signed(gx3_full, neg2_reg[0]);
            gy3_reg <= sat_signed(gy3_full, neg2_reg[1]);
            gz3_reg <= sat_signed(gz3_full, neg2_reg[2]);
        end
    end

    assign weight = w3_reg;
    assign grad_x = gx3_reg;
    assign grad_y = gy3_reg;
    assign grad_z = gz3_reg;

endmodule

// ----- hdl/bspline_weight_gradient.sv -----
// Top level of the cubic B-spline weight and gradient block: input register,
// three axis lanes, merging stages and pipeline flow control. Depends on bwg_pkg,
// bwg_lane and bwg_merge.
//
// Takes one particle/node pair per request and returns the interpolation weight
// (Q0.16) and its gradient (Q16.16, saturating). The pipeline is fully stalled only
// stage by stage, so one request is accepted every cycle while results are taken,
// and empty stages keep filling while the output waits. From accept to result a
// request passes one input register, six stages in each axis lane (each holding
// at most one multiplier) and three merging stages. inv_spacing resets to 1.0 and
// may be written through cfg_we/cfg_wdata only while no request is in flight.
module bspline_weight_gradient (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // particle_x, particle_y, particle_z, node_x, node_y, node_z (32 bits each)
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // weight (16), grad_x (32), grad_y (32), grad_z (32)
    output logic [111:0] m_tdata,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    localparam int NS = bwg_pkg::NUM_STAGES;
    localparam int NL = bwg_pkg::NUM_LANE_STAGES;

    logic [31:0]       inv_spacing_reg;
    logic [NS-1:0]     valid_reg;
    logic [NS-1:0]     valid_next;
    logic [NS-1:0]     stage_en;
    logic [191:0]      in_data_reg;
    bwg_pkg::pipe_en_t pipe_en;
    bwg_pkg::axis_t    axis_x, axis_y, axis_z;
    logic [15:0]       weight;
    logic [31:0]       grad_x, grad_y, grad_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_spacing_reg <= bwg_pkg::INV_SPACING_RESET;
        end else if (cfg_we) begin
            inv_spacing_reg <= cfg_wdata;
        end
    end

    // A stage loads when it is empty or its content moves on in the same cycle.
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            in_data_reg <= s_tdata;
        end
    end

    assign pipe_en.lane  = stage_en[NL:1];
    assign pipe_en.merge = stage_en[NS-1:NL+1];

    bwg_lane u_lane_x (
        .aclk         (aclk),
        .pipe_en      (pipe_en),
        .pos_particle (in_data_reg[31:0]),
        .pos_node     (in_data_reg[127:96]),
        .inv_spacing  (inv_spacing_reg),
        .axis_out     (axis_x)
    );

    bwg_lane u_lane_y (
        .aclk         (aclk),
        .pipe_en      (pipe_en),
        .pos_particle (in_data_reg[63:32]),
        .pos_node     (in_data_reg[159:128]),
        .inv_spacing  (inv_spacing_reg),
        .axis_out     (axis_y)
    );

    bwg_lane u_lane_z (
        .aclk         (aclk),
        .pipe_en      (pipe_en),
        .pos_particle (in_data_reg[95:64]),
        .pos_node     (in_data_reg[191:160]),
        .inv_spacing  (inv_spacing_reg),
        .axis_out     (axis_z)
    );

    bwg_merge u_merge (
        .aclk        (aclk),
        .pipe_en     (pipe_en),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .inv_spacing (inv_spacing_reg),
        .weight      (weight),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {grad_z, grad_y, grad_x, weight};

endmodule

// ----- hdl/bwg_checker.sv -----
// Port-level checker of the B-spline weight block, bound to the top level.
// Depends on bwg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bwg_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    // A stalled result stays put.
    `BWG_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // The weight never exceeds (2/3)^3.
    `BWG_ASSERT(a_weight_bound, aclk, aresetn, m_tvalid |-> m_tdata[15:0] <= bwg_pkg::WEIGHT_BOUND)

    // With the result side taking every cycle, the input side never stalls.
    `BWG_ASSERT(a_no_stall, aclk, aresetn, m_tready |-> s_tready)

    // Reset empties the pipeline.
    `BWG_ASSERT_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind bspline_weight_gradient bwg_checker u_bwg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
